>>> hdl/first_fit_pool_allocator_unit_assert.svh
// Assertion helpers used by the allocator walker (ffpa_walk).
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef FIRST_FIT_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFPA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFPA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/ffpa_pkg.sv
package ffpa_pkg;

   localparam int ALLOC_SIZE_W  = 17;
   localparam int FREE_OFFSET_W = 16;
   localparam int DATA_OFFSET_W = 16;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ALLOC     = 2'd0,
      STATUS_NO_FIT    = 2'd1,
      STATUS_FREED     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic                     req_type;
      logic [ALLOC_SIZE_W-1:0]  alloc_size;
      logic [FREE_OFFSET_W-1:0] free_offset;
   } ffpa_req_type;

   typedef struct packed {
      status_type               status;
      logic [DATA_OFFSET_W-1:0] data_offset;
   } ffpa_rsp_type;

endpackage

>>> hdl/ffpa_hdr_ram.sv
module ffpa_hdr_ram #(
   parameter int                DEPTH      = 16384,
   parameter int                DATA_W     = 18,
   parameter logic [DATA_W-1:0] RESET_WORD = '0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata
);

   localparam int ADDR_W = $clog2(DEPTH);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_raw_ff;
   logic              fresh0_ff;
   logic              use_reset_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_raw_ff <= mem[raddr];
      end
   end

   // Only the first header has a defined value after reset. It reads as the
   // whole-pool free block until the first write to that entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         fresh0_ff    <= 1'b1;
         use_reset_ff <= 1'b0;
      end else begin
         if (we && (waddr == ADDR_W'(0))) begin
            fresh0_ff <= 1'b0;
         end
         if (re) begin
            use_reset_ff <= fresh0_ff && (raddr == ADDR_W'(0));
         end
      end
   end

   assign rdata = use_reset_ff ? RESET_WORD : rdata_raw_ff;

endmodule

>>> hdl/ffpa_walk.sv
module ffpa_walk #(
   parameter int POOL_BYTES   = 65536,
   parameter int HEADER_BYTES = 8
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                start,
   input  ffpa_pkg::ffpa_req_type                              req,
   input  logic                                                slot_free,
   output logic                                                idle,
   output logic                                                done,
   output ffpa_pkg::ffpa_rsp_type                              rsp,
   output logic                                                mem_re,
   output logic [$clog2((POOL_BYTES+3)/4)-1:0]                 mem_raddr,
   input  logic [$clog2(POOL_BYTES+1):0]                       mem_rdata,
   output logic                                                mem_we,
   output logic [$clog2((POOL_BYTES+3)/4)-1:0]                 mem_waddr,
   output logic [$clog2(POOL_BYTES+1):0]                       mem_wdata
);

   import ffpa_pkg::*;

   localparam int POS_W  = $clog2(POOL_BYTES + 1);
   localparam int NEED_W = ALLOC_SIZE_W + 1;
   localparam int W      = ((POS_W > NEED_W) ? POS_W : NEED_W) + 1;
   localparam int DEPTH  = (POOL_BYTES + 3) / 4;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic [W-1:0] HDR  = W'(HEADER_BYTES);
   localparam logic [W-1:0] POOL = W'(POOL_BYTES);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_RD   = 7'b0000010,
      S_EVAL = 7'b0000100,
      S_WR   = 7'b0001000,
      S_NXT  = 7'b0010000,
      S_MNX  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic       op_ff, op_in;
   logic [W-1:0] need_ff, need_in;
   logic [W-1:0] target_ff, target_in;
   logic [W-1:0] pos_ff, pos_in;
   logic [W-1:0] dpos_ff, dpos_in;
   logic       hit_ff, hit_in;
   logic [W-1:0] prev_pos_ff, prev_pos_in;
   logic [W-1:0] prev_size_ff, prev_size_in;
   logic       prev_free_ff, prev_free_in;
   logic       have_prev_ff, have_prev_in;
   logic [W-1:0] base_pos_ff, base_pos_in;
   logic [W-1:0] base_size_ff, base_size_in;
   status_type status_ff, status_in;
   logic [DATA_OFFSET_W-1:0] off_ff, off_in;

   logic [W-1:0] rd_size;
   logic         rd_free;
   logic [W-1:0] add_a, add_b, add_sum;
   logic [W-1:0] mrg_a, mrg_sum;
   logic [W-1:0] need_hdr;
   logic [W-1:0] rem_size;
   logic [W-1:0] rd_byte;
   logic         fit, split, merge_prev, in_range, nxt_valid;

   assign rd_size = W'(mem_rdata[POS_W-1:0]);
   assign rd_free = mem_rdata[POS_W];

   // Pointer adder shared by the walk, the split point and the successor lookup.
   always_comb begin
      add_a = dpos_ff;
      add_b = rd_size;
      if (state_ff == S_RD) begin
         add_a = pos_ff;
         add_b = HDR;
      end else if (fit) begin
         add_b = need_ff;
      end
   end
   assign add_sum = add_a + add_b;

   // Size adder shared by both merges: a + size read + header.
   assign mrg_a   = (state_ff == S_MNX) ? base_size_ff : prev_size_ff;
   assign mrg_sum = mrg_a + rd_size + HDR;

   assign need_hdr   = need_ff + HDR;
   assign rem_size   = rd_size - need_hdr;
   assign fit        = (op_ff == OP_ALLOC) && rd_free && (rd_size >= need_ff);
   assign split      = rd_size > need_hdr;
   assign merge_prev = have_prev_ff && prev_free_ff;
   assign in_range   = add_sum <= POOL;
   assign nxt_valid  = pos_ff < POOL;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      need_in      = need_ff;
      target_in    = target_ff;
      pos_in       = pos_ff;
      dpos_in      = dpos_ff;
      hit_in       = hit_ff;
      prev_pos_in  = prev_pos_ff;
      prev_size_in = prev_size_ff;
      prev_free_in = prev_free_ff;
      have_prev_in = have_prev_ff;
      base_pos_in  = base_pos_ff;
      base_size_in = base_size_ff;
      status_in    = status_ff;
      off_in       = off_ff;
      mem_re       = 1'b0;
      mem_raddr    = pos_ff[ADDR_W+1:2];
      mem_we       = 1'b0;
      mem_waddr    = pos_ff[ADDR_W+1:2];
      mem_wdata    = {1'b0, rd_size[POS_W-1:0]};
      done         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in        = req.req_type;
               // Round the request up to a multiple of four bytes.
               need_in      = (W'(req.alloc_size) + W'(3)) & ~W'(3);
               target_in    = W'(req.free_offset);
               pos_in       = '0;
               have_prev_in = 1'b0;
               state_in     = S_RD;
            end
         end
         S_RD: begin
            dpos_in = add_sum;
            hit_in  = add_sum == target_ff;
            if (in_range) begin
               mem_re   = 1'b1;
               state_in = S_EVAL;
            end else begin
               status_in = (op_ff == OP_ALLOC) ? STATUS_NO_FIT : STATUS_NOT_FOUND;
               off_in    = '0;
               state_in  = S_DONE;
            end
         end
         S_EVAL: begin
            if (op_ff == OP_ALLOC) begin
               if (fit) begin
                  mem_we    = 1'b1;
                  status_in = STATUS_ALLOC;
                  off_in    = dpos_ff[DATA_OFFSET_W-1:0];
                  if (split) begin
                     // The remainder header goes first; the taken block next cycle.
                     mem_waddr = add_sum[ADDR_W+1:2];
                     mem_wdata = {1'b1, rem_size[POS_W-1:0]};
                     state_in  = S_WR;
                  end else begin
                     mem_wdata = {1'b0, rd_size[POS_W-1:0]};
                     state_in  = S_DONE;
                  end
               end else begin
                  pos_in   = add_sum;
                  state_in = S_RD;
               end
            end else if (hit_ff) begin
               base_pos_in  = merge_prev ? prev_pos_ff : pos_ff;
               base_size_in = merge_prev ? mrg_sum : rd_size;
               pos_in       = add_sum;
               status_in    = STATUS_FREED;
               off_in       = '0;
               state_in     = S_NXT;
            end else begin
               prev_pos_in  = pos_ff;
               prev_size_in = rd_size;
               prev_free_in = rd_free;
               have_prev_in = 1'b1;
               pos_in       = add_sum;
               state_in     = S_RD;
            end
         end
         S_WR: begin
            mem_we    = 1'b1;
            mem_wdata = {1'b0, need_ff[POS_W-1:0]};
            state_in  = S_DONE;
         end
         S_NXT: begin
            if (nxt_valid) begin
               mem_re   = 1'b1;
               state_in = S_MNX;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = base_pos_ff[ADDR_W+1:2];
               mem_wdata = {1'b1, base_size_ff[POS_W-1:0]};
               state_in  = S_DONE;
            end
         end
         S_MNX: begin
            mem_we    = 1'b1;
            mem_waddr = base_pos_ff[ADDR_W+1:2];
            mem_wdata = rd_free ? {1'b1, mrg_sum[POS_W-1:0]}
                                : {1'b1, base_size_ff[POS_W-1:0]};
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      need_ff      <= need_in;
      target_ff    <= target_in;
      pos_ff       <= pos_in;
      dpos_ff      <= dpos_in;
      hit_ff       <= hit_in;
      prev_pos_ff  <= prev_pos_in;
      prev_size_ff <= prev_size_in;
      prev_free_ff <= prev_free_in;
      have_prev_ff <= have_prev_in;
      base_pos_ff  <= base_pos_in;
      base_size_ff <= base_size_in;
      status_ff    <= status_in;
      off_ff       <= off_in;
   end

   assign idle            = state_ff == S_IDLE;
   assign rsp.status      = status_ff;
   assign rsp.data_offset = off_ff;

   assign rd_byte = W'({mem_raddr, 2'b00});

`include "first_fit_pool_allocator_unit_assert.svh"

   `FFPA_ASSERT_IMP(a_no_rw_clash, mem_we, !mem_re, "header read and write in one cycle")
   `FFPA_ASSERT_IMP(a_done_slot, done, slot_free, "result issued while output slot is full")
   `FFPA_ASSERT_IMP(a_read_bound, mem_re, rd_byte < POOL, "header read beyond the pool")
   `FFPA_ASSERT_NXT(a_done_idle, done, state_ff == S_IDLE, "walker not idle after a result")

endmodule

>>> hdl/first_fit_pool_allocator_unit.sv
// First-fit pool allocator: each block header visited costs one read and one evaluate step. At
// the match, an allocation writes the taken header, or with a split first the remainder header and
// then the taken header; a free reads the successor header and then writes the merged header, or
// writes it directly for the last block. A request that matches nothing walks every block first.
// One transaction at a time: the next is accepted once the result is registered, while that result
// may still wait. Synchronous reset leaves one free block covering the pool, with no clearing pass.
module first_fit_pool_allocator_unit #(
   parameter int POOL_BYTES   = 65536,
   parameter int HEADER_BYTES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ffpa_pkg::ffpa_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ffpa_pkg::ffpa_rsp_type rsp_payload
);

   import ffpa_pkg::*;

   localparam int POS_W  = $clog2(POOL_BYTES + 1);
   localparam int DATA_W = POS_W + 1;
   localparam int DEPTH  = (POOL_BYTES + 3) / 4;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [DATA_W-1:0] RESET_WORD = {1'b1, POS_W'(POOL_BYTES - HEADER_BYTES)};

   logic              walk_idle;
   logic              walk_done;
   logic              slot_free;
   ffpa_rsp_type      walk_rsp;
   logic              mem_re, mem_we;
   logic [ADDR_W-1:0] mem_raddr, mem_waddr;
   logic [DATA_W-1:0] mem_rdata, mem_wdata;
   logic              rsp_valid_ff, rsp_valid_in;
   ffpa_rsp_type      rsp_payload_ff, rsp_payload_in;

   assign req_ready = walk_idle;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   ffpa_walk #(
      .POOL_BYTES   (POOL_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid && req_ready),
      .req       (req_payload),
      .slot_free (slot_free),
      .idle      (walk_idle),
      .done      (walk_done),
      .rsp       (walk_rsp),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata)
   );

   ffpa_hdr_ram #(
      .DEPTH      (DEPTH),
      .DATA_W     (DATA_W),
      .RESET_WORD (RESET_WORD)
   ) u_hdr_ram (
      .clock (clock),
      .reset (reset),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata)
   );

   // Output register: a finished transaction waits here for the consumer.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (walk_done) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = walk_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> test/first_fit_pool_allocator_unit_tb.sv
module first_fit_pool_allocator_unit_tb;
   import ffpa_pkg::*;

   localparam int POOL_BYTES   = 65536;
   localparam int HEADER_BYTES = 8;
   localparam int SIZE_ALIGN   = 4;
   localparam int CHECK_COPY   = 0;
   localparam int PLAN_COPY    = 1;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 150;
   localparam int LIVE_CAP     = 24;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_PHASE   = 4;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int PRINT_CAP    = 50;

   logic         clock;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_ready;
   ffpa_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   ffpa_rsp_type rsp_payload;

   // Two copies of the header store: one follows the accepted transactions for
   // checking, the other runs ahead while stimulus is planned.
   int unsigned block_size [2][POOL_BYTES];
   bit          block_free [2][POOL_BYTES];

   ffpa_req_type             pending_req [$];
   ffpa_rsp_type             awaited_rsp [$];
   logic [DATA_OFFSET_W-1:0] live_offsets [$];
   logic [DATA_OFFSET_W-1:0] freed_offsets [$];

   ffpa_rsp_type oldest_rsp;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   bit           hold_start     = 1'b0;
   int           hold_left      = 0;
   int           cycle_count    = 0;
   int           error_count    = 0;
   int           requests_sent  = 0;
   int           status_count [4];

   first_fit_pool_allocator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic ffpa_rsp_type serve_request(input int copy, input ffpa_req_type r);
      ffpa_rsp_type    rsp;
      longint unsigned need;
      longint unsigned pos;
      longint unsigned prev;
      longint unsigned nxt;
      bit              have_prev;
      rsp.status      = STATUS_NO_FIT;
      rsp.data_offset = '0;
      pos       = 0;
      prev      = 0;
      have_prev = 1'b0;
      if (r.req_type == OP_ALLOC) begin
         need = 64'(r.alloc_size);
         if (need % SIZE_ALIGN != 0) need += SIZE_ALIGN - need % SIZE_ALIGN;
         while (pos + HEADER_BYTES <= POOL_BYTES) begin
            if (block_free[copy][pos] && block_size[copy][pos] >= need) begin
               // The leftover becomes its own free block only when it is larger than a header.
               if (block_size[copy][pos] > need + HEADER_BYTES &&
                   pos + HEADER_BYTES + need < POOL_BYTES) begin
                  block_free[copy][pos + HEADER_BYTES + need] = 1'b1;
                  block_size[copy][pos + HEADER_BYTES + need] =
                     32'(block_size[copy][pos] - HEADER_BYTES - need);
                  block_size[copy][pos] = 32'(need);
               end
               block_free[copy][pos] = 1'b0;
               rsp.status      = STATUS_ALLOC;
               rsp.data_offset = 16'(pos + HEADER_BYTES);
               return rsp;
            end
            pos += HEADER_BYTES + block_size[copy][pos];
         end
         return rsp;
      end
      rsp.status = STATUS_NOT_FOUND;
      while (pos + HEADER_BYTES <= POOL_BYTES) begin
         if (pos + HEADER_BYTES == r.free_offset) begin
            block_free[copy][pos] = 1'b1;
            if (have_prev && block_free[copy][prev]) begin
               block_size[copy][prev] += block_size[copy][pos] + HEADER_BYTES;
               pos = prev;
            end
            nxt = pos + block_size[copy][pos] + HEADER_BYTES;
            if (nxt < POOL_BYTES && block_free[copy][nxt]) begin
               block_size[copy][pos] += block_size[copy][nxt] + HEADER_BYTES;
            end
            rsp.status = STATUS_FREED;
            return rsp;
         end
         prev      = pos;
         have_prev = 1'b1;
         pos += HEADER_BYTES + block_size[copy][pos];
      end
      return rsp;
   endfunction

   function automatic ffpa_req_type alloc_req(input logic [ALLOC_SIZE_W-1:0] size);
      ffpa_req_type r;
      r.req_type    = OP_ALLOC;
      r.alloc_size  = size;
      r.free_offset = FREE_OFFSET_W'($urandom_range((1 << FREE_OFFSET_W) - 1));
      return r;
   endfunction

   function automatic ffpa_req_type free_req(input logic [FREE_OFFSET_W-1:0] offset);
      ffpa_req_type r;
      r.req_type    = OP_FREE;
      r.alloc_size  = ALLOC_SIZE_W'($urandom_range((1 << ALLOC_SIZE_W) - 1));
      r.free_offset = offset;
      return r;
   endfunction

   // Queues a request and keeps the list of allocated blocks that later frees draw on.
   task automatic plan_request(input ffpa_req_type r);
      ffpa_rsp_type rsp;
      rsp = serve_request(PLAN_COPY, r);
      pending_req.push_back(r);
      if (rsp.status == STATUS_ALLOC) begin
         live_offsets.push_back(rsp.data_offset);
      end else if (r.req_type == OP_FREE) begin
         for (int i = 0; i < live_offsets.size(); i++) begin
            if (live_offsets[i] == r.free_offset) begin
               live_offsets.delete(i);
               break;
            end
         end
         if (rsp.status == STATUS_FREED) begin
            freed_offsets.push_back(r.free_offset);
            if (freed_offsets.size() > 16) void'(freed_offsets.pop_front());
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_CAP) begin
         $display("[%0d] mismatch: %s", cycle_count, what);
      end
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_rsp.push_back(serve_request(CHECK_COPY, req_payload));
            requests_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= pending_req.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction, status %0d offset %0d",
                                         rsp_payload.status, rsp_payload.data_offset));
            end else begin
               oldest_rsp = awaited_rsp.pop_front();
               if (rsp_payload.status !== oldest_rsp.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_payload.status, oldest_rsp.status));
               end
               if (rsp_payload.data_offset !== oldest_rsp.data_offset) begin
                  report_mismatch($sformatf("data_offset %0d, expected %0d",
                                            rsp_payload.data_offset, oldest_rsp.data_offset));
               end
               status_count[oldest_rsp.status]++;
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Counts out the long receiver hold-off so the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d transactions outstanding.",
                  cycle_count, awaited_rsp.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [DATA_OFFSET_W-1:0] blk [$];
      logic [ALLOC_SIZE_W-1:0]  size;
      int                       pick;
      int                       draw;
      int                       k;

      for (int c = 0; c < 2; c++) begin
         block_size[c][0] = POOL_BYTES - HEADER_BYTES;
         block_free[c][0] = 1'b1;
      end

      // Directed opening: edge sizes, bad offsets, exact fits, double frees and merges.
      plan_request(free_req(16'd8));
      plan_request(free_req(16'd0));
      plan_request(free_req(16'hFFFF));
      plan_request(alloc_req(17'h1FFFF));
      plan_request(alloc_req(17'd65529));
      plan_request(alloc_req(17'd65528));
      plan_request(alloc_req(17'd0));
      plan_request(free_req(16'd8));
      plan_request(alloc_req(17'd0));
      plan_request(alloc_req(17'd1));
      plan_request(alloc_req(17'd3));
      plan_request(alloc_req(17'd4));
      plan_request(alloc_req(17'd5));
      blk = live_offsets;
      plan_request(free_req(blk[2]));
      plan_request(alloc_req(17'd4));
      plan_request(free_req(blk[2]));
      plan_request(free_req(blk[2]));
      plan_request(alloc_req(17'd0));
      plan_request(free_req(blk[2]));
      plan_request(free_req(blk[1]));
      plan_request(free_req(blk[3]));
      plan_request(free_req(blk[3]));
      plan_request(free_req(blk[0] + 16'd4));
      plan_request(free_req(blk[4]));
      plan_request(free_req(blk[0]));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_req.size() != 0 || req_valid || awaited_rsp.size() != 0) begin
         @(negedge clock);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 56;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 56;
            end
            default: begin
               send_idle_pct  = 34;
               recv_stall_pct = 34;
            end
         endcase

         // Mostly well-formed traffic: allocations and frees of live blocks, with some
         // double frees and stray offsets mixed in.
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (live_offsets.size() >= LIVE_CAP) pick = 60;
            if (pick >= 45 && pick < 85 && live_offsets.size() != 0) begin
               k = $urandom_range(live_offsets.size() - 1);
               plan_request(free_req(live_offsets[k]));
            end else if (pick >= 85 && pick < 92 && freed_offsets.size() != 0) begin
               k = $urandom_range(freed_offsets.size() - 1);
               plan_request(free_req(freed_offsets[k]));
            end else if (pick >= 92) begin
               if (live_offsets.size() != 0 && $urandom_range(1) == 1) begin
                  k = $urandom_range(live_offsets.size() - 1);
                  plan_request(free_req(live_offsets[k] + 16'(4 * $urandom_range(1, 3))));
               end else begin
                  plan_request(free_req(
                     FREE_OFFSET_W'($urandom_range((1 << FREE_OFFSET_W) - 1))));
               end
            end else begin
               draw = $urandom_range(99);
               if (draw < 40) size = ALLOC_SIZE_W'($urandom_range(64));
               else if (draw < 75) size = ALLOC_SIZE_W'($urandom_range(1024));
               else if (draw < 92) size = ALLOC_SIZE_W'($urandom_range(16384));
               else if (draw < 98) size = ALLOC_SIZE_W'($urandom_range(65536));
               else size = ALLOC_SIZE_W'($urandom_range((1 << ALLOC_SIZE_W) - 1, 65537));
               plan_request(alloc_req(size));
            end
         end

         if (ph == HOLD_PHASE) begin
            hold_start = 1'b1;
            @(negedge clock);
            hold_start = 1'b0;
         end

         // The next phase is planned only after every queued request is sent and every result has come back.
         while (pending_req.size() != 0 || req_valid || awaited_rsp.size() != 0) begin
            @(negedge clock);
         end
      end

      repeat (SETTLE_CYCLES) @(negedge clock);

      $display(
         "Ran %0d requests over %0d phases: %0d alloc, %0d no fit, %0d freed, %0d not found.",
         requests_sent, PHASES + 1, status_count[STATUS_ALLOC],
         status_count[STATUS_NO_FIT], status_count[STATUS_FREED], status_count[STATUS_NOT_FOUND]);
      $display("Idling mixes and one %0d-cycle receiver hold-off were applied; %0d mismatches.",
               HOLD_CYCLES, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/ffpa_pkg.sv
hdl/ffpa_hdr_ram.sv
hdl/ffpa_walk.sv
hdl/first_fit_pool_allocator_unit.sv
test/first_fit_pool_allocator_unit_tb.sv
